@@ sv/line_substring_filter_core_assert.svh @@
// ---------------------------------------------------------------------------
// Line substring filter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_FILTER_CORE_ASSERT_SVH
`define LINE_SUBSTRING_FILTER_CORE_ASSERT_SVH

// Implication in the same cycle.
`define LSF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle.
`define LSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lsf_pkg.sv @@
// ---------------------------------------------------------------------------
// Line substring filter package
// Constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package lsf_pkg;

  localparam int LINE_BYTES_DEF = 64;
  localparam int NEEDLE_MAX_DEF = 47;

  localparam int NEEDLE_WORDS = 6;
  localparam int WORD_W       = 64;
  localparam int LEN_W        = 6;
  localparam int CFG_IDX_W    = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN = 3'd6;

  localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

  localparam logic [7:0] NL_BYTE  = 8'h0A;
  localparam logic [7:0] NUL_BYTE = 8'h00;

  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } lsf_state_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_STATUS,
    OUT_BYTE,
    OUT_NL
  } lsf_out_sel_e;

  typedef struct packed {
    logic         acc_byte;   // store and search the incoming byte
    logic         set_found;
    logic         clr_found;
    logic         clr_line;
    logic         idx_clr;
    logic         idx_inc;
    lsf_out_sel_e out_sel;
    logic         out_done;
  } lsf_cmd_t;

  typedef struct packed {
    logic line_matched;
    logic line_nz;
    logic emit_end;     // read pointer at line end or at a zero byte
  } lsf_sts_t;

endpackage

@@ sv/lsf_datapath.sv @@
// ---------------------------------------------------------------------------
// Line substring filter datapath
// Needle registers, shift-and matcher, line memory and result register.
// ---------------------------------------------------------------------------
module lsf_datapath #(
  parameter int LINE_BYTES = lsf_pkg::LINE_BYTES_DEF,
  parameter int NEEDLE_MAX = lsf_pkg::NEEDLE_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lsf_pkg::WORD_W-1:0]     cfg_data_i,
  input  logic [7:0]                     text_byte_i,
  input  lsf_pkg::lsf_cmd_t              cmd_i,
  output lsf_pkg::lsf_sts_t              sts_o,
  output logic [7:0]                     out_byte_o,
  output logic                           byte_valid_o,
  output logic                           run_last_o,
  output logic                           done_res_o,
  output logic                           any_match_o
);
  import lsf_pkg::*;

  localparam int DEPTH = LINE_BYTES - 1;
  localparam int CW    = $clog2(LINE_BYTES);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [WORD_W-1:0] needle_q [NEEDLE_WORDS];
  logic [LEN_W-1:0]  len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NEEDLE_WORDS; w++) needle_q[w] <= '0;
      len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < REG_NEEDLE_LEN) begin
        needle_q[cfg_idx_i] <= cfg_data_i;
      end else if (cfg_idx_i == REG_NEEDLE_LEN) begin
        len_q <= cfg_data_i[LEN_W-1:0];
      end
    end
  end

  logic [LEN_W-1:0] len_eff;
  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(NEEDLE_MAX)) begin
      len_eff = LEN_W'(NEEDLE_MAX);
    end else begin
      len_eff = len_q;
    end
  end

  // shift-and matcher, one lane per needle position
  logic [NEEDLE_MAX-1:0] part_q, part_d, hit;

  for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_lane
    logic [7:0] nb;
    logic       prev;
    if (k < NEEDLE_WORDS * 8) begin : g_nb
      assign nb = needle_q[k / 8][(k % 8) * 8 +: 8];
    end else begin : g_nb0
      assign nb = NUL_BYTE;
    end
    if (k == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = part_q[k-1];
    end
    assign part_d[k] = prev && (nb != NUL_BYTE) && (nb == text_byte_i)
                       && (LEN_W'(k) < len_eff);
    assign hit[k]    = part_d[k] && (len_eff == LEN_W'(k + 1));
  end

  // line state
  logic [CW-1:0] count_q;
  logic          zero_q, matched_q, found_q;
  logic [CW-1:0] idx_q, idx_d;
  logic          room;

  assign room = count_q < CW'(DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      zero_q    <= 1'b0;
      part_q    <= '0;
      matched_q <= 1'b0;
      found_q   <= 1'b0;
      idx_q     <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.clr_line) begin
        count_q   <= '0;
        zero_q    <= 1'b0;
        part_q    <= '0;
        matched_q <= 1'b0;
      end else if (cmd_i.acc_byte && room) begin
        count_q <= count_q + CW'(1);
        if (!zero_q) begin
          if (text_byte_i == NUL_BYTE) begin
            zero_q <= 1'b1;
          end else begin
            part_q <= part_d;
            if (|hit) matched_q <= 1'b1;
          end
        end
      end
      if (cmd_i.set_found) begin
        found_q <= 1'b1;
      end else if (cmd_i.clr_found) begin
        found_q <= 1'b0;
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end
  end

  // line memory: one write port, one registered read port
  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_byte && room) mem_q[count_q[AW-1:0]] <= text_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (idx_d < CW'(DEPTH)) rd_data_q <= mem_q[idx_d[AW-1:0]];
  end

  assign sts_o.line_matched = matched_q;
  assign sts_o.line_nz      = count_q != '0;
  assign sts_o.emit_end     = (idx_q == count_q) || (rd_data_q == NUL_BYTE);

  // result register
  logic [7:0] obyte_q;
  logic       ovalid_q, olast_q, odone_q, oany_q;

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.out_sel)
      OUT_STATUS: begin
        obyte_q  <= NUL_BYTE;
        ovalid_q <= 1'b0;
        olast_q  <= 1'b1;
        odone_q  <= cmd_i.out_done;
        oany_q   <= cmd_i.out_done & found_q;
      end
      OUT_BYTE: begin
        obyte_q  <= rd_data_q;
        ovalid_q <= 1'b1;
        olast_q  <= 1'b0;
        odone_q  <= 1'b0;
        oany_q   <= 1'b0;
      end
      OUT_NL: begin
        obyte_q  <= NL_BYTE;
        ovalid_q <= 1'b1;
        olast_q  <= 1'b1;
        odone_q  <= cmd_i.out_done;
        oany_q   <= cmd_i.out_done & found_q;
      end
      default: begin
      end
    endcase
  end

  assign out_byte_o   = obyte_q;
  assign byte_valid_o = ovalid_q;
  assign run_last_o   = olast_q;
  assign done_res_o   = odone_q;
  assign any_match_o  = oany_q;

endmodule

@@ sv/lsf_ctrl.sv @@
// ---------------------------------------------------------------------------
// Line substring filter controller
// Accepts items, sequences line emission and owns the result valid flag.
// ---------------------------------------------------------------------------
`include "line_substring_filter_core_assert.svh"

module lsf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [7:0]        text_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lsf_pkg::lsf_sts_t sts_i,
  output lsf_pkg::lsf_cmd_t cmd_o
);
  import lsf_pkg::*;

  lsf_state_e state_q, state_d;
  logic       end_q, end_d;
  logic       oval_q, oval_d;
  logic       out_free, accept, is_nl, flush;

  assign out_free   = !oval_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_nl      = (op_i == OP_TEXT) && (text_byte_i == NL_BYTE);
  assign flush      = is_nl || ((op_i == OP_END) && sts_i.line_nz);

  // next state
  always_comb begin
    state_d = state_q;
    end_d   = end_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && flush && sts_i.line_matched) begin
          state_d = ST_EMIT;
          end_d   = op_i;
        end
      end
      ST_EMIT: begin
        if (out_free && sts_i.emit_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '{default: '0, out_sel: OUT_NONE};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!is_nl && (op_i == OP_TEXT)) begin
            cmd_o.acc_byte = 1'b1;
            cmd_o.out_sel  = OUT_STATUS;
          end else if (flush && sts_i.line_matched) begin
            cmd_o.set_found = 1'b1;
            cmd_o.idx_clr   = 1'b1;
          end else begin
            cmd_o.out_sel   = OUT_STATUS;
            cmd_o.out_done  = op_i;
            cmd_o.clr_line  = 1'b1;
            cmd_o.clr_found = op_i;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (sts_i.emit_end) begin
            cmd_o.out_sel   = OUT_NL;
            cmd_o.out_done  = end_q;
            cmd_o.clr_line  = 1'b1;
            cmd_o.clr_found = end_q;
          end else begin
            cmd_o.out_sel = OUT_BYTE;
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_sel != OUT_NONE) begin
      oval_d = 1'b1;
    end else if (out_ready_i) begin
      oval_d = 1'b0;
    end else begin
      oval_d = oval_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      end_q   <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
      oval_q  <= oval_d;
    end
  end

  assign out_valid_o = oval_q;

  `LSF_ASSERT_SAME(a_no_overwrite, cmd_o.out_sel != OUT_NONE, out_free,
                   "result overwritten before transfer")
  `LSF_ASSERT_SAME(a_emit_exit_nl, state_q == ST_EMIT && state_d == ST_IDLE,
                   cmd_o.out_sel == OUT_NL, "emission left without newline")
  `LSF_ASSERT_SAME(a_emit_matched, state_q == ST_EMIT, sts_i.line_matched,
                   "line state lost during emission")
  `LSF_ASSERT_NEXT(a_flush_emits, accept && flush && sts_i.line_matched,
                   state_q == ST_EMIT, "matching flush did not start emission")

endmodule

@@ sv/line_substring_filter_core.sv @@
// ---------------------------------------------------------------------------
// Line substring filter core
// Fixed-string line filter: buffers each text line, emits lines holding the
// configured needle, followed by a newline, and reports a summary at end.
// ---------------------------------------------------------------------------
// Results: status results load the result register directly; emitted bytes
//   pass the line memory read register first. A matching newline or end item
//   parks the input while the line's bytes and then the newline are emitted.
// Reset: rst_ni asynchronous, active low; clears control, needle (zero,
//   length 1) and line state; line memory is not cleared and needs no pass.
module line_substring_filter_core #(
  parameter int LINE_BYTES = lsf_pkg::LINE_BYTES_DEF,  // 2..256, stores LINE_BYTES-1
  parameter int NEEDLE_MAX = lsf_pkg::NEEDLE_MAX_DEF   // 1..63
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [lsf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lsf_pkg::WORD_W-1:0]    cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [7:0]                    text_byte_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          byte_valid_o,
  output logic                          run_last_o,
  output logic                          done_res_o,
  output logic                          any_match_o
);
  import lsf_pkg::*;

  // Controller and datapath talk only through these two bundles.
  lsf_cmd_t cmd;
  lsf_sts_t sts;

  // The controller decides, per transfer, whether the item is a plain byte
  // (store, search, status result), a flush of a non-matching or empty line
  // (status result, clear) or a flush of a matching line, which parks the
  // input while the stored bytes drain through the result register.
  lsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .text_byte_i (text_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath keeps the needle, runs the shift-and matcher over each byte
  // combinationally, writes the line memory and holds the result payload. The
  // result register sits between the two sides, so a new item can be taken in
  // the same cycle as the previous result is transferred.
  lsf_datapath #(
    .LINE_BYTES (LINE_BYTES),
    .NEEDLE_MAX (NEEDLE_MAX)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .text_byte_i  (text_byte_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .done_res_o   (done_res_o),
    .any_match_o  (any_match_o)
  );

endmodule

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// Line substring filter core testbench
// Streams text bytes and end markers through the core under random idling
// on both channels and checks every returned byte against a line predictor.
// ---------------------------------------------------------------------------
module tb;
  import lsf_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int STORE_BYTES  = LINE_BYTES_DEF - 1;   // bytes kept per line
  localparam int NEEDLE_BYTES = NEEDLE_MAX_DEF;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 40;                   // per random phase
  localparam int LONG_HOLD    = 300;                  // receiver hold-off, cycles
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_WORD_0 = '0;  // words follow on

  typedef struct {
    logic       op;
    logic [7:0] text;
  } text_item_t;

  // one returned result, field for field
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       done_res;
    logic       any_match;
  } line_res_t;

  // DUT ports; every input starts at a known value
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [WORD_W-1:0]    cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 op_i        = OP_TEXT;
  logic [7:0]           text_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [7:0]           out_byte_o;
  logic                 byte_valid_o;
  logic                 run_last_o;
  logic                 done_res_o;
  logic                 any_match_o;

  // queues between stimulus, driver and monitor
  text_item_t text_item_q[$];
  line_res_t  line_res_q[$];

  // predictor copy of the needle registers
  logic [WORD_W-1:0] pat_word [NEEDLE_WORDS];
  logic [LEN_W-1:0]  pat_len;
  // predictor copy of the line state
  logic [7:0]              cur_line [STORE_BYTES];
  int                      cur_count;
  logic                    cur_zero;
  logic [NEEDLE_BYTES-1:0] cur_partial;
  logic                    cur_hit;
  logic                    stream_hit;

  // staging for a full needle load
  logic [WORD_W-1:0] stage_word [NEEDLE_WORDS];
  logic [LEN_W-1:0]  stage_len;

  // idling controls, set per phase by the stimulus
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_arm   = 1'b0;
  int bad_cnt    = 0;

  line_substring_filter_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .text_byte_i  (text_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .done_res_o   (done_res_o),
    .any_match_o  (any_match_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // Line predictor
  // -------------------------------------------------------------------------

  // length 0 reads as 1, anything above the maximum saturates
  function automatic int pat_span();
    int n;
    n = int'(pat_len);
    if (n == 0) n = 1;
    if (n > NEEDLE_BYTES) n = NEEDLE_BYTES;
    return n;
  endfunction

  function automatic logic [7:0] pat_byte(int k);
    return pat_word[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic void clear_line();
    cur_count   = 0;
    cur_zero    = 1'b0;
    cur_partial = '0;
    cur_hit     = 1'b0;
  endfunction

  // shift-and search; a zero needle byte never matches
  function automatic void search_byte(logic [7:0] c);
    logic [NEEDLE_BYTES:0]   shifted;
    logic [NEEDLE_BYTES-1:0] nxt;
    int                      span;
    span    = pat_span();
    shifted = {cur_partial, 1'b1};
    nxt     = '0;
    for (int k = 0; k < span; k++) begin
      if (shifted[k] && pat_byte(k) != NUL_BYTE && pat_byte(k) == c) nxt[k] = 1'b1;
    end
    cur_partial = nxt;
    if (nxt[span-1]) cur_hit = 1'b1;
  endfunction

  // matching line: stored bytes up to the first zero, then a newline
  function automatic void flush_line();
    line_res_t r;
    if (cur_hit) begin
      for (int i = 0; i < cur_count; i++) begin
        if (cur_line[i] == NUL_BYTE) break;
        r            = '0;
        r.out_byte   = cur_line[i];
        r.byte_valid = 1'b1;
        line_res_q.push_back(r);
      end
      r            = '0;
      r.out_byte   = NL_BYTE;
      r.byte_valid = 1'b1;
      line_res_q.push_back(r);
      stream_hit = 1'b1;
    end
    clear_line();
  endfunction

  // queues the results one accepted item causes
  function automatic void filter_accept(logic op, logic [7:0] c);
    int        base;
    line_res_t r;
    base = line_res_q.size();
    if (op == OP_TEXT) begin
      if (c == NL_BYTE) begin
        flush_line();
      end else if (cur_count < STORE_BYTES) begin
        cur_line[cur_count] = c;
        cur_count++;
        if (!cur_zero) begin
          if (c == NUL_BYTE) cur_zero = 1'b1;
          else search_byte(c);
        end
      end
    end else if (cur_count > 0) begin
      flush_line();
    end else begin
      clear_line();
    end
    // nothing emitted: a single status result
    if (line_res_q.size() == base) begin
      r = '0;
      line_res_q.push_back(r);
    end
    r = line_res_q.pop_back();
    r.run_last = 1'b1;
    if (op == OP_END) begin
      r.done_res  = 1'b1;
      r.any_match = stream_hit;
      stream_hit  = 1'b0;
    end
    line_res_q.push_back(r);
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_alpha(bit zero_ok);
    if (zero_ok && $urandom_range(0, 11) == 0) return NUL_BYTE;
    case ($urandom_range(0, 5))
      0:       return 8'h61;
      1:       return 8'h62;
      2:       return 8'h63;
      3:       return 8'hFF;
      4:       return 8'h80;
      default: return 8'h01;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_word(bit zero_ok);
    logic [WORD_W-1:0] w;
    for (int b = 0; b < 8; b++) w[b * 8 +: 8] = pick_alpha(zero_ok);
    return w;
  endfunction

  function automatic void push_item(logic op, logic [7:0] c);
    text_item_t it;
    it.op   = op;
    it.text = c;
    text_item_q.push_back(it);
  endfunction

  // line body byte: leans on needle bytes so partial matches build up
  function automatic logic [7:0] body_byte();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 55)      c = pat_byte($urandom_range(0, pat_span() - 1));
    else if (r < 85) c = pick_alpha(1'b0);
    else if (r < 88) c = NUL_BYTE;
    else             c = 8'($urandom_range(0, 255));
    if (c == NL_BYTE) c = NL_BYTE + 8'd1;
    return c;
  endfunction

  // one line, usually well formed with the needle somewhere in it;
  // sometimes bare noise, sometimes no closing newline
  function automatic int gen_line();
    int span, at, r, cnt;
    bit with_pat;
    cnt = 0;
    if ($urandom_range(0, 99) < 10) begin
      span = $urandom_range(1, 10);
      for (int i = 0; i < span; i++) push_item(OP_TEXT, 8'($urandom_range(0, 255)));
      return span;
    end
    r = $urandom_range(0, 99);
    if (r < 80)      span = $urandom_range(0, 12);
    else if (r < 95) span = $urandom_range(13, 40);
    else             span = $urandom_range(41, 80);
    with_pat = ($urandom_range(0, 99) < 60);
    at       = $urandom_range(0, span);
    for (int i = 0; i <= span; i++) begin
      if (with_pat && i == at) begin
        for (int k = 0; k < pat_span(); k++) begin
          push_item(OP_TEXT, pat_byte(k));
          cnt++;
        end
      end
      if (i < span) begin
        push_item(OP_TEXT, body_byte());
        cnt++;
      end
    end
    if ($urandom_range(0, 99) < 90) begin
      push_item(OP_TEXT, NL_BYTE);
      cnt++;
    end
    return cnt;
  endfunction

  // all seven registers, one write per cycle, then the enable drops
  task automatic load_needle();
    for (int w = 0; w <= NEEDLE_WORDS; w++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      if (w < NEEDLE_WORDS) begin
        cfg_idx_i   <= REG_NEEDLE_WORD_0 + w[CFG_IDX_W-1:0];
        cfg_data_i  <= stage_word[w];
        pat_word[w] = stage_word[w];
      end else begin
        cfg_idx_i  <= REG_NEEDLE_LEN;
        cfg_data_i <= {{(WORD_W - LEN_W){1'b0}}, stage_len};
        pat_len    = stage_len;
      end
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender stops until every queued item is taken and every result is back
  task automatic drain();
    while (text_item_q.size() != 0 || in_valid_i || line_res_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // -------------------------------------------------------------------------
  // Input driver: offers queued items, predicts on each transfer
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin : in_drive
    text_item_t nxt;
    logic       send;
    int         tx_gap_left;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      tx_gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) filter_accept(op_i, text_byte_i);
      if (in_valid_i && !in_ready_o) begin
        send = 1'b1;                    // payload held until the transfer
      end else if (tx_gap_left > 0) begin
        tx_gap_left--;
        send = 1'b0;
      end else if (text_item_q.size() != 0) begin
        nxt = text_item_q.pop_front();
        op_i        <= nxt.op;
        text_byte_i <= nxt.text;
        send        = 1'b1;
        tx_gap_left = tx_idle_on ? idle_len() : 0;
      end else begin
        send = 1'b0;
      end
      in_valid_i <= send;
    end
  end

  // -------------------------------------------------------------------------
  // Receiver ready: random stalls plus one long hold-off, counted here
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin : out_drive
    int  rx_gap_left;
    int  hold_left;
    bit  hold_done;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_gap_left = 0;
      hold_left   = 0;
      hold_done   = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      // results back up, the core fills and stalls its input
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
      out_ready_i <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      rx_gap_left = rx_idle_on ? idle_len() : 0;
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: each result transfer against the oldest expectation
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin : res_check
    line_res_t got;
    line_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.out_byte   = out_byte_o;
      got.byte_valid = byte_valid_o;
      got.run_last   = run_last_o;
      got.done_res   = done_res_o;
      got.any_match  = any_match_o;
      if (line_res_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10)
          $display("unexpected result: byte %h bv %b last %b done %b any %b",
                   got.out_byte, got.byte_valid, got.run_last, got.done_res,
                   got.any_match);
      end else begin
        want = line_res_q.pop_front();
        if (got !== want) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display({"result mismatch: exp byte %h bv %b last %b done %b any %b, ",
                      "got byte %h bv %b last %b done %b any %b"},
                     want.out_byte, want.byte_valid, want.run_last, want.done_res,
                     want.any_match, got.out_byte, got.byte_valid, got.run_last,
                     got.done_res, got.any_match);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog
  // -------------------------------------------------------------------------
  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stim
    int got_items;
    // reset values of the predictor: zero needle, length 1, empty line
    foreach (pat_word[w]) pat_word[w] = '0;
    pat_len    = LEN_RESET;
    stream_hit = 1'b0;
    clear_line();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    // reset needle is a zero byte: nothing can match
    push_item(OP_TEXT, 8'h61);
    push_item(OP_TEXT, NL_BYTE);
    push_item(OP_END, 8'h00);
    drain();

    // needle "ab"
    foreach (stage_word[w]) stage_word[w] = '0;
    stage_word[0] = 64'h6261;
    stage_len     = 6'd2;
    load_needle();
    // plain match
    push_item(OP_TEXT, 8'h78);
    push_item(OP_TEXT, 8'h61);
    push_item(OP_TEXT, 8'h62);
    push_item(OP_TEXT, NL_BYTE);
    // zero byte before the needle: rest of the line is not searched
    push_item(OP_TEXT, 8'h61);
    push_item(OP_TEXT, NUL_BYTE);
    push_item(OP_TEXT, 8'h61);
    push_item(OP_TEXT, 8'h62);
    push_item(OP_TEXT, NL_BYTE);
    // zero byte after the match: emission stops there
    push_item(OP_TEXT, 8'h61);
    push_item(OP_TEXT, 8'h62);
    push_item(OP_TEXT, NUL_BYTE);
    push_item(OP_TEXT, 8'hFF);
    push_item(OP_TEXT, NL_BYTE);
    // needle swapped mid-line to "ac": the partial 'a' carries over
    push_item(OP_TEXT, 8'h7A);
    push_item(OP_TEXT, 8'h61);
    drain();
    stage_word[0] = 64'h6361;
    load_needle();
    push_item(OP_TEXT, 8'h63);
    push_item(OP_END, 8'hFF);      // flushes the pending matching line
    push_item(OP_END, 8'h00);      // empty line, status only
    drain();
    // length zero behaves as one: needle is just 'a'
    stage_len = 6'd0;
    load_needle();
    push_item(OP_TEXT, 8'h61);
    push_item(OP_TEXT, 8'hFF);
    push_item(OP_END, 8'h00);
    drain();

    // --- random phases ---
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          // widest needle, all bytes 0xFF; no idling on either side
          foreach (stage_word[w]) stage_word[w] = '1;
          stage_len  = LEN_W'(NEEDLE_BYTES);
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b0;
        end
        1: begin
          // top length saturates to the maximum
          foreach (stage_word[w]) stage_word[w] = rand_word(1'b0);
          stage_len  = '1;
          tx_idle_on = 1'b1;
          rx_idle_on = 1'b1;
        end
        2: begin
          foreach (stage_word[w]) stage_word[w] = rand_word(1'b0);
          stage_len = 6'd0;
          hold_arm  = 1'b1;
        end
        3: begin
          foreach (stage_word[w]) stage_word[w] = rand_word(1'b0);
          stage_len  = LEN_W'($urandom_range(1, 3));
          tx_idle_on = 1'b0;
        end
        4: begin
          // all-zero needle never matches
          foreach (stage_word[w]) stage_word[w] = '0;
          stage_len  = LEN_W'($urandom_range(1, NEEDLE_BYTES));
          tx_idle_on = 1'b1;
          rx_idle_on = 1'b0;
        end
        default: begin
          foreach (stage_word[w]) stage_word[w] = rand_word(1'b1);
          stage_len  = LEN_W'($urandom_range(1, 8));
          tx_idle_on = 1'b1;
          rx_idle_on = 1'b1;
        end
      endcase
      load_needle();
      got_items = 0;
      while (got_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 4) begin
          push_item(OP_END, 8'($urandom_range(0, 255)));
          got_items++;
        end else begin
          got_items += gen_line();
        end
      end
      push_item(OP_END, 8'($urandom_range(0, 255)));
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (bad_cnt == 0 && line_res_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
